// ===== src/lid_heater_regulator_top_assert.svh =====
// assertion macros used by the checker file
`ifndef LID_HEATER_REGULATOR_TOP_ASSERT_SVH
`define LID_HEATER_REGULATOR_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LHR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lid heater regulator assertion failed");

// next-cycle implication, disabled during reset
`define LHR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lid heater regulator assertion failed");

`endif

// ===== src/lhr_pkg.sv =====
package lhr_pkg;

   // regulation modes
   typedef enum logic [1:0] {
      MODE_STOP   = 2'd0,
      MODE_MANUAL = 2'd1,
      MODE_OPEN   = 2'd2,
      MODE_CLOSED = 2'd3
   } mode_type;

   // request commands
   typedef enum logic [1:0] {
      CMD_TICK       = 2'd0,
      CMD_START      = 2'd1,
      CMD_STOP       = 2'd2,
      CMD_SET_MANUAL = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type            cmd;
      logic signed [15:0] sample;
      logic [15:0]        manual_drive;
   } req_type;

   typedef struct packed {
      logic [15:0] drive;
      mode_type    mode;
   } rsp_type;

   // configuration registers as seen by the datapath
   typedef struct packed {
      logic signed [15:0] setpoint;
      logic signed [10:0] gain;
      logic signed [15:0] enter_closed_level;
      logic signed [15:0] leave_closed_level;
      logic [15:0]        open_loop_drive;
      logic [15:0]        drive_limit;
   } cfg_type;

   // register map
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] REG_SETPOINT        = 3'd0;
   localparam logic [2:0] REG_GAIN            = 3'd1;
   localparam logic [2:0] REG_ENTER_CLOSED    = 3'd2;
   localparam logic [2:0] REG_LEAVE_CLOSED    = 3'd3;
   localparam logic [2:0] REG_OPEN_LOOP_DRIVE = 3'd4;
   localparam logic [2:0] REG_DRIVE_LIMIT     = 3'd5;

   // register reset values
   localparam logic signed [15:0] SETPOINT_RST        = 16'sd5597;
   localparam logic signed [10:0] GAIN_RST            = 11'sd120;
   localparam logic signed [15:0] ENTER_CLOSED_RST    = 16'sd3927;
   localparam logic signed [15:0] LEAVE_CLOSED_RST    = 16'sd3264;
   localparam logic [15:0]        OPEN_LOOP_DRIVE_RST = 16'd32767;
   localparam logic [15:0]        DRIVE_LIMIT_RST     = 16'd20000;

endpackage

// ===== src/lid_heater_regulator_top.sv =====
// Lid heater regulator: stop, manual, open loop and closed loop heater drive.
// Request channel (req_valid/req_ready, req_payload) carries a command: a tick
// with one sensor sample, start heating, stop heating, or set manual drive.
// Every request yields exactly one response (rsp_valid/rsp_ready,
// rsp_payload) with the drive and mode left after that request.
// An accepted request waits in the request register until the response side
// is free. Throughput: one request per cycle unless responses stall; the path
// between the request register and the drive/mode register holds one 11x17
// multiply, a compare and a clamp.
// The drive/mode register is itself the response register; it only updates
// when the response side is free, so a stalled receiver holds the response
// and the request register, and req_ready drops once both are full.
// Configuration goes through the APB port (registers at 4*index); write it
// only while no request is in flight.
// Reset (synchronous) empties both stages, sets stop mode with zero drive and
// loads the default register values.
module lid_heater_regulator_top
   import lhr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   cfg_type            cfg;
   req_type            req_ff;
   req_type            req_in;
   logic               req_vld_ff;
   logic               req_vld_in;
   logic               rsp_vld_ff;
   logic               rsp_vld_in;
   mode_type           mode_ff;
   mode_type           mode_in;
   logic [15:0]        drive_ff;
   logic [15:0]        drive_in;
   logic               adv;
   logic signed [16:0] diff;
   logic signed [27:0] prod;
   logic signed [28:0] raw;
   logic signed [28:0] limit_ext;
   logic [15:0]        sat_drive;

   lhr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // handshake control
   assign adv       = req_vld_ff & (~rsp_vld_ff | rsp_ready);
   assign req_ready = ~req_vld_ff | adv;
   assign rsp_valid = rsp_vld_ff;

   always_comb begin
      req_in     = req_ff;
      req_vld_in = req_vld_ff;
      if (req_valid && req_ready) begin
         req_in     = req_payload;
         req_vld_in = 1'b1;
      end else if (adv) begin
         req_vld_in = 1'b0;
      end
      if (adv) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   // proportional term and raw drive
   assign diff      = {cfg.setpoint[15], cfg.setpoint} - {req_ff.sample[15], req_ff.sample};
   assign prod      = cfg.gain * diff;
   assign limit_ext = {13'd0, cfg.drive_limit};

   always_comb begin
      case (mode_ff)
         MODE_OPEN:   raw = {13'd0, cfg.open_loop_drive};
         MODE_CLOSED: raw = {prod[27], prod};
         default:     raw = '0;
      endcase
   end

   // clamp to zero..drive_limit
   always_comb begin
      if (raw > limit_ext) begin
         sat_drive = cfg.drive_limit;
      end else if (raw < 0) begin
         sat_drive = 16'd0;
      end else begin
         sat_drive = raw[15:0];
      end
   end

   // mode and drive update
   always_comb begin
      mode_in  = mode_ff;
      drive_in = drive_ff;
      if (adv) begin
         case (req_ff.cmd)
            CMD_TICK: begin
               case (mode_ff)
                  MODE_STOP: begin
                     mode_in  = MODE_OPEN;
                     drive_in = sat_drive;
                  end
                  MODE_OPEN: begin
                     drive_in = sat_drive;
                     if (req_ff.sample > cfg.enter_closed_level) begin
                        mode_in = MODE_CLOSED;
                     end
                  end
                  MODE_CLOSED: begin
                     drive_in = sat_drive;
                     if (req_ff.sample < cfg.leave_closed_level) begin
                        mode_in = MODE_OPEN;
                     end
                  end
                  default: begin
                     mode_in = mode_ff;
                  end
               endcase
            end
            CMD_START: begin
               mode_in = MODE_CLOSED;
            end
            CMD_STOP: begin
               mode_in = MODE_STOP;
            end
            CMD_SET_MANUAL: begin
               mode_in  = MODE_MANUAL;
               drive_in = req_ff.manual_drive;
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         mode_ff    <= MODE_STOP;
         drive_ff   <= 16'd0;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         mode_ff    <= mode_in;
         drive_ff   <= drive_in;
      end
   end

   // request payload register
   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   assign rsp_payload.drive = drive_ff;
   assign rsp_payload.mode  = mode_ff;

endmodule

// ===== src/lhr_csr.sv =====
module lhr_csr
   import lhr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign cfg     = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_SETPOINT:        cfg_in.setpoint           = pwdata[15:0];
            REG_GAIN:            cfg_in.gain               = pwdata[10:0];
            REG_ENTER_CLOSED:    cfg_in.enter_closed_level = pwdata[15:0];
            REG_LEAVE_CLOSED:    cfg_in.leave_closed_level = pwdata[15:0];
            REG_OPEN_LOOP_DRIVE: cfg_in.open_loop_drive    = pwdata[15:0];
            REG_DRIVE_LIMIT:     cfg_in.drive_limit        = pwdata[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint           <= SETPOINT_RST;
         cfg_ff.gain               <= GAIN_RST;
         cfg_ff.enter_closed_level <= ENTER_CLOSED_RST;
         cfg_ff.leave_closed_level <= LEAVE_CLOSED_RST;
         cfg_ff.open_loop_drive    <= OPEN_LOOP_DRIVE_RST;
         cfg_ff.drive_limit        <= DRIVE_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux, raw register bits zero extended
   always_comb begin
      case (reg_idx)
         REG_SETPOINT:        prdata = {16'd0, cfg_ff.setpoint};
         REG_GAIN:            prdata = {21'd0, cfg_ff.gain};
         REG_ENTER_CLOSED:    prdata = {16'd0, cfg_ff.enter_closed_level};
         REG_LEAVE_CLOSED:    prdata = {16'd0, cfg_ff.leave_closed_level};
         REG_OPEN_LOOP_DRIVE: prdata = {16'd0, cfg_ff.open_loop_drive};
         REG_DRIVE_LIMIT:     prdata = {16'd0, cfg_ff.drive_limit};
         default:             prdata = 32'd0;
      endcase
   end

endmodule

// ===== src/lhr_checker.sv =====
`include "lid_heater_regulator_top_assert.svh"

module lhr_checker
   import lhr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // a stalled response holds its value
   `LHR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_payload))

   // requests only back up when a response is waiting
   `LHR_ASSERT_NOW(a_ready_backpressure, clock, reset, !req_ready, rsp_valid)

   // manual mode never goes straight to open loop
   `LHR_ASSERT_NEXT(a_manual_exit, clock, reset,
                    rsp_valid && rsp_ready && rsp_payload.mode == MODE_MANUAL,
                    !rsp_valid || rsp_payload.mode != MODE_OPEN)

endmodule

bind lid_heater_regulator_top lhr_checker u_lhr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
